>>> rtl/pqa_pkg.sv
// ============================================================================
// pqa_pkg
// Shared widths, register codes and helpers for the quadrilateral alert block.
// ============================================================================
`default_nettype none

package pqa_pkg;

   localparam int COORD_BITS  = 20;
   localparam int MAX_APPS    = 16;
   localparam int PORT_W      = 4;
   localparam int CORNER_W    = 60;
   localparam int NUM_CORNERS = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_AXES    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_D = 2'd3;

   localparam logic OP_POSITION = 1'b0;

   localparam int APP_CMP_W = 9;
   localparam logic [APP_CMP_W-1:0] APP_LIMIT = APP_CMP_W'(MAX_APPS);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int LO_W   = DOT_W / 2;
   localparam int HI_W   = DOT_W - LO_W;
   localparam int HH_W   = 2 * HI_W;
   localparam int HL_W   = HI_W + LO_W + 1;
   localparam int LL_W   = 2 * LO_W;
   localparam int WIDE_W = 2 * DOT_W + 3;

   localparam int NUM_VECS = 4;
   localparam int VEC_V0   = 0;
   localparam int VEC_V1   = 1;
   localparam int VEC_V2   = 2;
   localparam int VEC_W    = 3;

   localparam int NUM_DOTS = 8;
   localparam int DOT_G00  = 0;
   localparam int DOT_G01  = 1;
   localparam int DOT_G11  = 2;
   localparam int DOT_G12  = 3;
   localparam int DOT_G22  = 4;
   localparam int DOT_H0   = 5;
   localparam int DOT_H1   = 6;
   localparam int DOT_H2   = 7;

   localparam int NUM_TRIS = 2;
   localparam int NUM_MULS = 6;
   localparam int MUL_DEN_P = 0;
   localparam int MUL_DEN_Q = 1;
   localparam int MUL_NU_P  = 2;
   localparam int MUL_NU_Q  = 3;
   localparam int MUL_NV_P  = 4;
   localparam int MUL_NV_Q  = 5;

   localparam int NUM_STAGES = 6;

   typedef logic [CORNER_W-1:0] corner_type;

   function automatic logic signed [COORD_BITS-1:0] corner_coord(input corner_type c,
                                                                  input int axis);
      return signed'(c[axis*COORD_BITS +: COORD_BITS]);
   endfunction

   function automatic logic nonpos(input logic [WIDE_W-1:0] v);
      return v[WIDE_W-1] || (v == '0);
   endfunction

endpackage

`default_nettype wire

>>> rtl/point_in_quadrilateral_alert_top.sv
// ============================================================================
// point_in_quadrilateral_alert_top
// Alerts the arrival port of every position report that falls in the
// configured quadrilateral ABCD, tested as triangles ABC and ACD.
// ============================================================================
// The request channel carries one item per report: op, the 3D position and
// the arrival port. Only position reports whose port is in range can cause a
// result; every other item is taken and dropped. The response channel
// carries one alert item with the port for each report that lies inside.
// Corners A to D are written through the csr port; the user must write them
// only while the block holds no items, which the block itself leaves unchecked.
// The datapath is a pipeline of six stages plus the output register. One
// item is taken in every cycle while req_stall is low. The long pole is the
// 44 by 44 bit product of dot products, cut into 22 bit partial products in
// one stage and summed in the next.
// When the receiver stalls, items keep moving forward into empty stages;
// req_stall rises only once every stage and the output register are full.
// Reset empties the pipeline and clears all four corners to zero.
// ============================================================================
`default_nettype none

module point_in_quadrilateral_alert_top
   import pqa_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_op,
   input  wire logic signed [COORD_BITS-1:0] req_pos_x,
   input  wire logic signed [COORD_BITS-1:0] req_pos_y,
   input  wire logic signed [COORD_BITS-1:0] req_pos_z,
   input  wire logic        [PORT_W-1:0]     req_app_port,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic             [PORT_W-1:0]     rsp_alert_port,
   input  wire logic                         csr_write_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CORNER_W-1:0]   csr_wdata
);

   localparam int DOT_A [NUM_DOTS] = '{VEC_V0, VEC_V0, VEC_V1, VEC_V1,
                                       VEC_V2, VEC_W, VEC_W, VEC_W};
   localparam int DOT_B [NUM_DOTS] = '{VEC_V0, VEC_V1, VEC_V1, VEC_V2,
                                       VEC_V2, VEC_V0, VEC_V1, VEC_V2};
   localparam int TRI_D00 [NUM_TRIS] = '{DOT_G00, DOT_G11};
   localparam int TRI_D01 [NUM_TRIS] = '{DOT_G01, DOT_G12};
   localparam int TRI_D11 [NUM_TRIS] = '{DOT_G11, DOT_G22};
   localparam int TRI_D20 [NUM_TRIS] = '{DOT_H0, DOT_H1};
   localparam int TRI_D21 [NUM_TRIS] = '{DOT_H1, DOT_H2};

   corner_type corner_ff [NUM_CORNERS];

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   en;
   logic [PORT_W-1:0]     port_ff [NUM_STAGES];

   logic signed [DIFF_W-1:0] vec      [NUM_VECS][NUM_AXES];
   logic signed [DIFF_W-1:0] w_in     [NUM_AXES];
   logic signed [DIFF_W-1:0] w_ff     [NUM_AXES];
   logic signed [PROD_W-1:0] prod_in  [NUM_DOTS][NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff  [NUM_DOTS][NUM_AXES];
   logic signed [DOT_W-1:0]  dot_in   [NUM_DOTS];
   logic signed [DOT_W-1:0]  dot_ff   [NUM_DOTS];
   logic        [DOT_W-1:0]  mul_a    [NUM_TRIS][NUM_MULS];
   logic        [DOT_W-1:0]  mul_b    [NUM_TRIS][NUM_MULS];
   logic signed [HH_W-1:0]   hh_in    [NUM_TRIS][NUM_MULS];
   logic signed [HH_W-1:0]   hh_ff    [NUM_TRIS][NUM_MULS];
   logic signed [HL_W-1:0]   hl_in    [NUM_TRIS][NUM_MULS];
   logic signed [HL_W-1:0]   hl_ff    [NUM_TRIS][NUM_MULS];
   logic signed [HL_W-1:0]   lh_in    [NUM_TRIS][NUM_MULS];
   logic signed [HL_W-1:0]   lh_ff    [NUM_TRIS][NUM_MULS];
   logic        [LL_W-1:0]   ll_in    [NUM_TRIS][NUM_MULS];
   logic        [LL_W-1:0]   ll_ff    [NUM_TRIS][NUM_MULS];
   logic        [WIDE_W-1:0] big_in   [NUM_TRIS][NUM_MULS];
   logic        [WIDE_W-1:0] big_ff   [NUM_TRIS][NUM_MULS];
   logic        [WIDE_W-1:0] den_in   [NUM_TRIS];
   logic        [WIDE_W-1:0] den_ff   [NUM_TRIS];
   logic        [WIDE_W-1:0] nu_in    [NUM_TRIS];
   logic        [WIDE_W-1:0] nu_ff    [NUM_TRIS];
   logic        [WIDE_W-1:0] nv_in    [NUM_TRIS];
   logic        [WIDE_W-1:0] nv_ff    [NUM_TRIS];
   logic        [WIDE_W-1:0] slack    [NUM_TRIS];
   logic        [NUM_TRIS-1:0] tri_hit;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PORT_W-1:0] rsp_port_ff;
   logic              item_ok;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            corner_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CORNER_A: corner_ff[0] <= csr_wdata;
            CSR_CORNER_B: corner_ff[1] <= csr_wdata;
            CSR_CORNER_C: corner_ff[2] <= csr_wdata;
            CSR_CORNER_D: corner_ff[3] <= csr_wdata;
            default:      corner_ff[0] <= corner_ff[0];
         endcase
      end
   end

   // Pipeline flow control: a stage loads when it is empty or drains.
   always_comb begin
      en[NUM_STAGES] = !rsp_valid_ff || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];
   assign item_ok   = (req_op == OP_POSITION)
                      && (APP_CMP_W'(req_app_port) < APP_LIMIT);

   always_comb begin
      vld_in[0] = en[0] ? (req_valid && item_ok) : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Edge vectors from A change only with configuration; vec[3] is the point.
   always_comb begin
      for (int k = 0; k < NUM_VECS - 1; k++) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            vec[k][ax] = DIFF_W'(corner_coord(corner_ff[k+1], ax))
                         - DIFF_W'(corner_coord(corner_ff[0], ax));
         end
      end
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         vec[VEC_W][ax] = w_ff[ax];
      end
   end

   // Stage 0: the point relative to corner A.
   always_comb begin
      w_in[0] = DIFF_W'(req_pos_x) - DIFF_W'(corner_coord(corner_ff[0], 0));
      w_in[1] = DIFF_W'(req_pos_y) - DIFF_W'(corner_coord(corner_ff[0], 1));
      w_in[2] = DIFF_W'(req_pos_z) - DIFF_W'(corner_coord(corner_ff[0], 2));
   end

   // Stage 1: coordinate products of every dot product.
   always_comb begin
      for (int j = 0; j < NUM_DOTS; j++) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            prod_in[j][ax] = vec[DOT_A[j]][ax] * vec[DOT_B[j]][ax];
         end
      end
   end

   // Stage 2: dot products.
   always_comb begin
      for (int j = 0; j < NUM_DOTS; j++) begin
         dot_in[j] = DOT_W'(prod_ff[j][0]) + DOT_W'(prod_ff[j][1])
                     + DOT_W'(prod_ff[j][2]);
      end
   end

   // Stage 3: partial products of the wide products, split at LO_W bits.
   always_comb begin
      for (int t = 0; t < NUM_TRIS; t++) begin
         mul_a[t][MUL_DEN_P] = dot_ff[TRI_D00[t]];
         mul_b[t][MUL_DEN_P] = dot_ff[TRI_D11[t]];
         mul_a[t][MUL_DEN_Q] = dot_ff[TRI_D01[t]];
         mul_b[t][MUL_DEN_Q] = dot_ff[TRI_D01[t]];
         mul_a[t][MUL_NU_P]  = dot_ff[TRI_D11[t]];
         mul_b[t][MUL_NU_P]  = dot_ff[TRI_D20[t]];
         mul_a[t][MUL_NU_Q]  = dot_ff[TRI_D01[t]];
         mul_b[t][MUL_NU_Q]  = dot_ff[TRI_D21[t]];
         mul_a[t][MUL_NV_P]  = dot_ff[TRI_D00[t]];
         mul_b[t][MUL_NV_P]  = dot_ff[TRI_D21[t]];
         mul_a[t][MUL_NV_Q]  = dot_ff[TRI_D01[t]];
         mul_b[t][MUL_NV_Q]  = dot_ff[TRI_D20[t]];
         for (int m = 0; m < NUM_MULS; m++) begin
            hh_in[t][m] = $signed(mul_a[t][m][DOT_W-1:LO_W])
                          * $signed(mul_b[t][m][DOT_W-1:LO_W]);
            hl_in[t][m] = $signed(mul_a[t][m][DOT_W-1:LO_W])
                          * $signed({1'b0, mul_b[t][m][LO_W-1:0]});
            lh_in[t][m] = $signed({1'b0, mul_a[t][m][LO_W-1:0]})
                          * $signed(mul_b[t][m][DOT_W-1:LO_W]);
            ll_in[t][m] = mul_a[t][m][LO_W-1:0] * mul_b[t][m][LO_W-1:0];
         end
      end
   end

   // Stage 4: full products from the partial products.
   always_comb begin
      for (int t = 0; t < NUM_TRIS; t++) begin
         for (int m = 0; m < NUM_MULS; m++) begin
            big_in[t][m] = (WIDE_W'(hh_ff[t][m]) << (2 * LO_W))
                           + (WIDE_W'(hl_ff[t][m]) << LO_W)
                           + (WIDE_W'(lh_ff[t][m]) << LO_W)
                           + WIDE_W'(ll_ff[t][m]);
         end
      end
   end

   // Stage 5: denominator and the two numerators of each triangle.
   always_comb begin
      for (int t = 0; t < NUM_TRIS; t++) begin
         den_in[t] = big_ff[t][MUL_DEN_P] - big_ff[t][MUL_DEN_Q];
         nu_in[t]  = big_ff[t][MUL_NU_P] - big_ff[t][MUL_NU_Q];
         nv_in[t]  = big_ff[t][MUL_NV_P] - big_ff[t][MUL_NV_Q];
      end
   end

   // Inside test; a zero denominator means a degenerate triangle.
   always_comb begin
      for (int t = 0; t < NUM_TRIS; t++) begin
         slack[t] = den_ff[t] - nu_ff[t] - nv_ff[t];
         if (den_ff[t] == '0) begin
            tri_hit[t] = 1'b0;
         end else if (den_ff[t][WIDE_W-1]) begin
            tri_hit[t] = nonpos(nu_ff[t]) && nonpos(nv_ff[t]) && nonpos(slack[t]);
         end else begin
            tri_hit[t] = !nu_ff[t][WIDE_W-1] && !nv_ff[t][WIDE_W-1]
                         && !slack[t][WIDE_W-1];
         end
      end
   end

   assign rsp_valid_in = en[NUM_STAGES] ? (vld_ff[NUM_STAGES-1] && (|tri_hit))
                                        : rsp_valid_ff;

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         w_ff       <= w_in;
         port_ff[0] <= req_app_port;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            port_ff[k] <= port_ff[k-1];
         end
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         dot_ff <= dot_in;
      end
      if (en[3]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
      if (en[4]) begin
         big_ff <= big_in;
      end
      if (en[5]) begin
         den_ff <= den_in;
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
      end
      if (en[NUM_STAGES]) begin
         rsp_port_ff <= port_ff[NUM_STAGES-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alert_port = rsp_port_ff;

endmodule

`default_nettype wire

>>> sim/point_in_quadrilateral_alert_top_tb.sv
// ============================================================================
// point_in_quadrilateral_alert_top_tb
// Self-checking bench for the quadrilateral alert block. A queue-fed driver
// sends position reports and other messages. A predictor checks each report
// against triangles ABC and ACD in exact wide integer arithmetic and queues
// the alert port it expects. A monitor compares every alert with the oldest
// one queued. The corners are rewritten between phases while the block is
// idle, and the phases cycle through four patterns of sender gaps and
// receiver stalls.
// ============================================================================
`default_nettype none

module point_in_quadrilateral_alert_top_tb;
   import pqa_pkg::*;

   localparam logic OP_OTHER       = 1'b1;
   localparam int   RESET_CYCLES   = 11;
   localparam int   DRAIN_CYCLES   = 24;
   localparam int   WATCHDOG_LIMIT = 5000;
   localparam int   RANDOM_PER_SET = 180;
   localparam longint COORD_MAX    = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN    = -(64'sd1 <<< (COORD_BITS - 1));

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic                         op;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic        [PORT_W-1:0]     port;
   } report_type;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } point_type;

   typedef logic signed [127:0] wide_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_op = 1'b0;
   logic signed [COORD_BITS-1:0] req_pos_x = '0;
   logic signed [COORD_BITS-1:0] req_pos_y = '0;
   logic signed [COORD_BITS-1:0] req_pos_z = '0;
   logic        [PORT_W-1:0]     req_app_port = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic        [PORT_W-1:0]     rsp_alert_port;
   logic                         csr_write_en = 1'b0;
   logic        [CSR_IDX_W-1:0]  csr_index = '0;
   logic        [CORNER_W-1:0]   csr_wdata = '0;

   report_type        pending_reports[$];
   logic [PORT_W-1:0] alert_due_q[$];
   corner_type        corner_model[NUM_CORNERS];
   report_type        bus_report;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   point_in_quadrilateral_alert_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_app_port   (req_app_port),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_alert_port (rsp_alert_port),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic enqueue_report(input report_type r);
      pending_reports.insert(pending_reports.size(), r);
   endtask

   task automatic enqueue_alert(input logic [PORT_W-1:0] port);
      alert_due_q.insert(alert_due_q.size(), port);
   endtask

   function automatic point_type corner_point(input corner_type c);
      point_type p;
      p.x = longint'($signed(c[COORD_BITS-1:0]));
      p.y = longint'($signed(c[2*COORD_BITS-1:COORD_BITS]));
      p.z = longint'($signed(c[3*COORD_BITS-1:2*COORD_BITS]));
      return p;
   endfunction

   function automatic point_type point_diff(input point_type a, input point_type b);
      point_type r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      r.z = a.z - b.z;
      return r;
   endfunction

   function automatic longint dot3(input point_type a, input point_type b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   function automatic bit in_barycentric_tri(input point_type p, input point_type a,
                                             input point_type b, input point_type c);
      point_type e0, e1, e2;
      longint    g00, g01, g11, g20, g21;
      wide_type  den, nu, nv, slack;
      e0    = point_diff(b, a);
      e1    = point_diff(c, a);
      e2    = point_diff(p, a);
      g00   = dot3(e0, e0);
      g01   = dot3(e0, e1);
      g11   = dot3(e1, e1);
      g20   = dot3(e2, e0);
      g21   = dot3(e2, e1);
      den   = wide_type'(g00) * wide_type'(g11) - wide_type'(g01) * wide_type'(g01);
      nu    = wide_type'(g11) * wide_type'(g20) - wide_type'(g01) * wide_type'(g21);
      nv    = wide_type'(g00) * wide_type'(g21) - wide_type'(g01) * wide_type'(g20);
      slack = den - (nu + nv);
      if (den == 0) begin
         return 1'b0;
      end
      if (den > 0) begin
         return nu >= 0 && nv >= 0 && slack >= 0;
      end
      return nu <= 0 && nv <= 0 && slack <= 0;
   endfunction

   function automatic bit report_in_quad(input report_type r);
      point_type p, a, b, c, d;
      if (r.op != OP_POSITION || int'(r.port) >= MAX_APPS) begin
         return 1'b0;
      end
      p.x = longint'(r.x);
      p.y = longint'(r.y);
      p.z = longint'(r.z);
      a = corner_point(corner_model[CSR_CORNER_A]);
      b = corner_point(corner_model[CSR_CORNER_B]);
      c = corner_point(corner_model[CSR_CORNER_C]);
      d = corner_point(corner_model[CSR_CORNER_D]);
      return in_barycentric_tri(p, a, b, c) || in_barycentric_tri(p, a, c, d);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         return COORD_BITS'(COORD_MAX);
      end
      if (v < COORD_MIN) begin
         return COORD_BITS'(COORD_MIN);
      end
      return COORD_BITS'(v);
   endfunction

   function automatic longint rand_coord(input int span);
      logic signed [COORD_BITS-1:0] raw;
      if (span > COORD_MAX) begin
         raw = COORD_BITS'($urandom);
         return longint'(raw);
      end
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   function automatic corner_type pack_corner(input longint x, input longint y,
                                              input longint z);
      return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
   endfunction

   // Points are spread over one of the two triangles and a little past its
   // edges, with small noise in x and y and larger noise in z.
   function automatic report_type near_report();
      report_type r;
      point_type  a, b, c;
      longint     s, t;
      a = corner_point(corner_model[CSR_CORNER_A]);
      if ($urandom_range(1) == 0) begin
         b = corner_point(corner_model[CSR_CORNER_B]);
         c = corner_point(corner_model[CSR_CORNER_C]);
      end else begin
         b = corner_point(corner_model[CSR_CORNER_C]);
         c = corner_point(corner_model[CSR_CORNER_D]);
      end
      s = $urandom_range(1100);
      t = $urandom_range(1100 - s);
      r.op   = OP_POSITION;
      r.x    = clamp_coord(a.x + ((b.x - a.x) * s + (c.x - a.x) * t) / 1000
                           + longint'($urandom_range(6)) - 3);
      r.y    = clamp_coord(a.y + ((b.y - a.y) * s + (c.y - a.y) * t) / 1000
                           + longint'($urandom_range(6)) - 3);
      r.z    = clamp_coord(a.z + ((b.z - a.z) * s + (c.z - a.z) * t) / 1000
                           + longint'($urandom_range(100)) - 50);
      r.port = PORT_W'($urandom_range(15));
      return r;
   endfunction

   task automatic add_report(input logic op, input longint x, input longint y,
                             input longint z, input int port);
      report_type r;
      r.op   = op;
      r.x    = COORD_BITS'(x);
      r.y    = COORD_BITS'(y);
      r.z    = COORD_BITS'(z);
      r.port = PORT_W'(port);
      enqueue_report(r);
   endtask

   task automatic add_random_reports(input int count);
      report_type r;
      int         pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            r.op   = (pick < 12) ? OP_OTHER : OP_POSITION;
            r.x    = COORD_BITS'($urandom);
            r.y    = COORD_BITS'($urandom);
            r.z    = COORD_BITS'($urandom);
            r.port = PORT_W'($urandom_range(15));
         end else begin
            r = near_report();
         end
         enqueue_report(r);
      end
   endtask

   task automatic wait_results_done();
      while (pending_reports.size() != 0 || req_valid || alert_due_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic settle_block();
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_corner(input logic [CSR_IDX_W-1:0] idx, input corner_type value);
      @(posedge clock);
      csr_write_en      <= 1'b1;
      csr_index         <= idx;
      csr_wdata         <= value;
      corner_model[idx]  = value;
      @(posedge clock);
      csr_write_en      <= 1'b0;
   endtask

   task automatic write_quad(input corner_type a, input corner_type b,
                             input corner_type c, input corner_type d);
      settle_block();
      write_corner(CSR_CORNER_A, a);
      write_corner(CSR_CORNER_B, b);
      write_corner(CSR_CORNER_C, c);
      write_corner(CSR_CORNER_D, d);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 73;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 73;
         end
         default: begin
            send_idle_pct = 14;
            rsp_stall_pct = 14;
         end
      endcase
   endtask

   task automatic write_random_quad(input int span, input bit planar);
      longint zp;
      zp = rand_coord(span);
      write_quad(pack_corner(rand_coord(span), rand_coord(span), planar ? zp : rand_coord(span)),
                 pack_corner(rand_coord(span), rand_coord(span), planar ? zp : rand_coord(span)),
                 pack_corner(rand_coord(span), rand_coord(span), planar ? zp : rand_coord(span)),
                 pack_corner(rand_coord(span), rand_coord(span), planar ? zp : rand_coord(span)));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall && report_in_quad(bus_report)) begin
            enqueue_alert(bus_report.port);
         end
         if (!req_valid || !req_stall) begin
            if (pending_reports.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               bus_report    = pending_reports.pop_front();
               req_valid    <= 1'b1;
               req_op       <= bus_report.op;
               req_pos_x    <= bus_report.x;
               req_pos_y    <= bus_report.y;
               req_pos_z    <= bus_report.z;
               req_app_port <= bus_report.port;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      logic [PORT_W-1:0] due_port;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alert_due_q.size() == 0) begin
               $display("%0t: unexpected alert, expected none, actual %0d",
                        $time, rsp_alert_port);
               mismatch_count++;
            end else begin
               due_port = alert_due_q.pop_front();
               if (rsp_alert_port !== due_port) begin
                  $display("%0t: alert_port mismatch, expected %0d, actual %0d",
                           $time, due_port, rsp_alert_port);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         corner_model[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // All corners coincide at the origin after reset, so both triangles
      // are degenerate and nothing is inside.
      set_idling(IDLE_NONE);
      add_report(OP_POSITION, 0, 0, 0, 0);
      add_report(OP_POSITION, COORD_MIN, COORD_MIN, COORD_MIN, 15);
      add_report(OP_POSITION, COORD_MAX, COORD_MAX, COORD_MAX, 7);
      add_report(OP_OTHER, 0, 0, 0, 3);

      // Square in the plane z = 100: corners, edges and the shared diagonal
      // count as inside, one step past an edge does not.
      write_quad(pack_corner(-4000, -4000, 100), pack_corner(4000, -4000, 100),
                 pack_corner(4000, 4000, 100), pack_corner(-4000, 4000, 100));
      add_report(OP_POSITION, -4000, -4000, 100, 0);
      add_report(OP_POSITION, 4000, -4000, 100, 1);
      add_report(OP_POSITION, 4000, 4000, 100, 2);
      add_report(OP_POSITION, -4000, 4000, 100, 15);
      add_report(OP_POSITION, 0, -4000, 100, 4);
      add_report(OP_POSITION, 4000, 0, 100, 5);
      add_report(OP_POSITION, -4000, 0, 100, 6);
      add_report(OP_POSITION, 1234, 1234, 100, 8);
      add_report(OP_POSITION, 100, 200, COORD_MAX, 9);
      add_report(OP_POSITION, 4001, 0, 100, 10);
      add_report(OP_POSITION, 0, -4001, 100, 11);
      add_report(OP_OTHER, 0, 0, 100, 12);
      add_report(OP_POSITION, COORD_MAX, COORD_MAX, COORD_MAX, 15);
      add_report(OP_POSITION, COORD_MIN, COORD_MIN, COORD_MIN, 0);
      add_report(OP_POSITION, 0, 0, COORD_MIN, 13);

      for (int k = 0; k < 8; k++) begin
         case (k)
            0: write_quad(pack_corner(COORD_MIN, COORD_MIN, COORD_MIN),
                          pack_corner(COORD_MAX, COORD_MIN, 0),
                          pack_corner(COORD_MAX, COORD_MAX, COORD_MAX),
                          pack_corner(COORD_MIN, COORD_MAX, 0));
            1: write_quad(pack_corner(0, 0, 0), pack_corner(1000, 1000, 1000),
                          pack_corner(2000, 2000, 2000), pack_corner(0, 5000, 0));
            2: write_random_quad(int'(COORD_MAX) + 1, 1'b0);
            3: write_random_quad(3000, 1'b1);
            4: write_random_quad(3000, 1'b0);
            5: write_quad(pack_corner(-777, 321, 55), pack_corner(-777, 321, 55),
                          pack_corner(-777, 321, 55), pack_corner(-777, 321, 55));
            6: write_random_quad(int'(COORD_MAX) + 1, 1'b1);
            default: write_random_quad(500, 1'b0);
         endcase
         set_idling(idle_mode_type'(k % 4));
         if (k == 2) begin
            add_random_reports(RANDOM_PER_SET / 2);
            wait_results_done();
            add_random_reports(RANDOM_PER_SET / 2);
         end else begin
            add_random_reports(RANDOM_PER_SET);
         end
      end

      settle_block();
      if (mismatch_count == 0 && alert_due_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/pqa_pkg.sv
rtl/point_in_quadrilateral_alert_top.sv
sim/point_in_quadrilateral_alert_top_tb.sv
